FILE: hw/rtl/cdr_pkg.sv
package cdr_pkg;

  // Field widths.
  localparam int TEMP_W    = 15;
  localparam int DAYLEN_W  = 16;
  localparam int RATE_W    = 16;
  localparam int ALPHA_W   = 16;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Logarithm unit: quotient of num * 2^30 / den, normalized mantissa, Q6.16 result.
  localparam int LOG_SHIFT  = 30;
  localparam int DIV_Q_W    = TEMP_W + LOG_SHIFT;
  localparam int MANT_W     = LOG_SHIFT + 1;
  localparam int FRAC_W     = 16;
  localparam int LOG_EXP_W  = 6;
  localparam int LOG_W      = LOG_EXP_W + FRAC_W;

  // Power-of-two unit.
  localparam int EXP_Y_W     = 25;
  localparam int EXP_IP_W    = EXP_Y_W - FRAC_W;
  localparam int POW_W       = 32;
  localparam int EXP_BASE_IP = 14;
  localparam int EXP_SAT_IP  = 17;

  // Exponent derivation: round(2^28 / L).
  localparam int ALPHA_NUM_W = 29;

  // Q16 constants.
  localparam int Q16_W = 17;
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [Q16_W-1:0] LOG2E_Q16 = 17'd94548;

  // Reset values of the registers and of the derived exponent.
  localparam logic [TEMP_W-1:0]   RST_TEMP_LOWER   = 15'd1024;
  localparam logic [TEMP_W-1:0]   RST_TEMP_OPTIMUM = 15'd3840;
  localparam logic [TEMP_W-1:0]   RST_TEMP_UPPER   = 15'd7168;
  localparam logic [DAYLEN_W-1:0] RST_DAYLEN_CRIT  = 16'd21914;
  localparam logic [DAYLEN_W-1:0] RST_DAYLEN_SLOPE = 16'd4227;
  localparam logic [RATE_W-1:0]   RST_RMAX_VEG     = 16'd5197;
  localparam logic [RATE_W-1:0]   RST_RMAX_TUBER   = 16'd1704;
  localparam logic [RATE_W-1:0]   RST_RMAX_SEN     = 16'd793;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA        = 16'd3639;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TEMP_LOWER,
    REG_TEMP_OPTIMUM,
    REG_TEMP_UPPER,
    REG_DAYLEN_CRITICAL,
    REG_DAYLEN_SLOPE,
    REG_RATE_MAX_VEG,
    REG_RATE_MAX_TUBER,
    REG_RATE_MAX_SEN
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_CHECK,
    CFG_INJECT,
    CFG_WAIT,
    CFG_DIV
  } cfg_state_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_lower;
    logic signed [TEMP_W-1:0] temp_optimum;
    logic signed [TEMP_W-1:0] temp_upper;
    logic [DAYLEN_W-1:0]      daylen_critical;
    logic [DAYLEN_W-1:0]      daylen_slope;
    logic [RATE_W-1:0]        rate_max_veg;
    logic [RATE_W-1:0]        rate_max_tuber;
    logic [RATE_W-1:0]        rate_max_sen;
    logic [ALPHA_W-1:0]       alpha;
    logic                     alpha_valid;
  } cfg_regs_t;

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = n;
    for (int it = 0; it < 32; it++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root 2^(2^-k) in Q30, by repeated square roots of 2.0.
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      if (j <= k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[31:0];
  endfunction

endpackage

FILE: hw/rtl/cdr_log2.sv
module cdr_log2 #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [cdr_pkg::TEMP_W-1:0]        num,
  input  logic [cdr_pkg::TEMP_W-1:0]        den,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [cdr_pkg::LOG_W-1:0]  log_value,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int NW    = cdr_pkg::TEMP_W;
  localparam int QW    = cdr_pkg::DIV_Q_W;
  localparam int MW    = cdr_pkg::MANT_W;
  localparam int FW    = cdr_pkg::FRAC_W;
  localparam int EW    = cdr_pkg::LOG_EXP_W;
  localparam int POS_W = $clog2(QW);

  // Long division, one quotient bit per stage.
  logic              dv_r    [QW];
  logic [NW-1:0]     drem_r  [QW];
  logic [QW-1:0]     dq_r    [QW];
  logic [NW-1:0]     dnum_r  [QW];
  logic [NW-1:0]     dden_r  [QW];
  logic [SIDE_W-1:0] dside_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int BIT = QW - 1 - i;
    logic              v_in;
    logic [NW-1:0]     rem_in;
    logic [QW-1:0]     q_in;
    logic [NW-1:0]     num_in;
    logic [NW-1:0]     den_in;
    logic [SIDE_W-1:0] side_in;
    logic              dbit;
    logic [NW:0]       rem2;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign num_in  = num;
      assign den_in  = den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = dv_r[i-1];
      assign rem_in  = drem_r[i-1];
      assign q_in    = dq_r[i-1];
      assign num_in  = dnum_r[i-1];
      assign den_in  = dden_r[i-1];
      assign side_in = dside_r[i-1];
    end

    if (BIT >= QW - NW) begin : g_num_bit
      assign dbit = num_in[BIT-(QW-NW)];
    end else begin : g_zero_bit
      assign dbit = 1'b0;
    end

    assign rem2 = {rem_in, dbit};
    assign ge   = (rem2 >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i] <= 1'b0;
      end else begin
        dv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      drem_r[i]  <= ge ? NW'(rem2 - {1'b0, den_in}) : rem2[NW-1:0];
      dq_r[i]    <= {q_in[QW-2:0], ge};
      dnum_r[i]  <= num_in;
      dden_r[i]  <= den_in;
      dside_r[i] <= side_in;
    end
  end

  // Leading-one position of the quotient.
  logic              lv_r;
  logic [QW-1:0]     lq_r;
  logic [POS_W-1:0]  lpos_r;
  logic [SIDE_W-1:0] lside_r;
  logic [POS_W-1:0]  lpos_nxt;

  always_comb begin
    lpos_nxt = '0;
    for (int j = 0; j < QW; j++) begin
      if (dq_r[QW-1][j]) begin
        lpos_nxt = POS_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else begin
      lv_r <= dv_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    lq_r    <= dq_r[QW-1];
    lpos_r  <= lpos_nxt;
    lside_r <= dside_r[QW-1];
  end

  // Normalize the mantissa into [1, 2).
  logic              nv_r;
  logic [MW-1:0]     nm_r;
  logic [EW-1:0]     ne_r;
  logic [SIDE_W-1:0] nside_r;
  logic [MW-1:0]     nm_nxt;
  logic [EW-1:0]     ne_nxt;

  always_comb begin
    if (lpos_r >= POS_W'(MW - 1)) begin
      nm_nxt = MW'(lq_r >> (lpos_r - POS_W'(MW - 1)));
    end else begin
      nm_nxt = MW'(lq_r << (POS_W'(MW - 1) - lpos_r));
    end
    ne_nxt = EW'(lpos_r) - EW'(MW - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else begin
      nv_r <= lv_r;
    end
  end

  always_ff @(posedge clk) begin
    nm_r    <= nm_nxt;
    ne_r    <= ne_nxt;
    nside_r <= lside_r;
  end

  // Fraction bits by repeated squaring, one bit per stage.
  logic              sv_r    [FW];
  logic [MW-1:0]     sm_r    [FW];
  logic [FW-1:0]     sf_r    [FW];
  logic [EW-1:0]     se_r    [FW];
  logic [SIDE_W-1:0] sside_r [FW];

  for (genvar k = 0; k < FW; k++) begin : g_sq
    logic              v_in;
    logic [MW-1:0]     m_in;
    logic [FW-1:0]     f_in;
    logic [EW-1:0]     e_in;
    logic [SIDE_W-1:0] side_in;
    logic [2*MW-1:0]   sq;
    logic [MW:0]       sq_top;

    if (k == 0) begin : g_first
      assign v_in    = nv_r;
      assign m_in    = nm_r;
      assign f_in    = '0;
      assign e_in    = ne_r;
      assign side_in = nside_r;
    end else begin : g_next
      assign v_in    = sv_r[k-1];
      assign m_in    = sm_r[k-1];
      assign f_in    = sf_r[k-1];
      assign e_in    = se_r[k-1];
      assign side_in = sside_r[k-1];
    end

    assign sq     = (2*MW)'(m_in) * (2*MW)'(m_in);
    assign sq_top = sq[2*MW-1:MW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else begin
        sv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      sm_r[k]    <= sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
      sf_r[k]    <= {f_in[FW-2:0], sq_top[MW]};
      se_r[k]    <= e_in;
      sside_r[k] <= side_in;
    end
  end

  assign out_valid = sv_r[FW-1];
  assign log_value = {se_r[FW-1], sf_r[FW-1]};
  assign out_side  = sside_r[FW-1];

endmodule

FILE: hw/rtl/cdr_exp2.sv
module cdr_exp2 #(
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [cdr_pkg::EXP_Y_W-1:0]  y,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_valid,
  output logic [cdr_pkg::POW_W-1:0]           pow,
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int YW  = cdr_pkg::EXP_Y_W;
  localparam int FW  = cdr_pkg::FRAC_W;
  localparam int IPW = cdr_pkg::EXP_IP_W;
  localparam int MW  = cdr_pkg::MANT_W;
  localparam int PW  = cdr_pkg::POW_W;
  localparam int SW  = IPW + 1;
  localparam logic [MW-1:0] MANT_ONE = MW'(1) << (MW - 1);

  // Split into integer part (floor) and fraction.
  logic                  iv_r;
  logic signed [IPW-1:0] iip_r;
  logic [FW-1:0]         if_r;
  logic [SIDE_W-1:0]     iside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    iip_r   <= y[YW-1:FW];
    if_r    <= y[FW-1:0];
    iside_r <= in_side;
  end

  // Product of the roots selected by the fraction bits, one root per stage.
  logic                  rv_r    [FW];
  logic [MW-1:0]         rm_r    [FW];
  logic signed [IPW-1:0] rip_r   [FW];
  logic [FW-1:0]         rf_r    [FW];
  logic [SIDE_W-1:0]     rside_r [FW];

  for (genvar k = 1; k <= FW; k++) begin : g_root
    localparam logic [MW-1:0] ROOT = MW'(cdr_pkg::exp2_root(k));
    logic                  v_in;
    logic [MW-1:0]         m_in;
    logic signed [IPW-1:0] ip_in;
    logic [FW-1:0]         f_in;
    logic [SIDE_W-1:0]     side_in;
    logic [2*MW-1:0]       prod;

    if (k == 1) begin : g_first
      assign v_in    = iv_r;
      assign m_in    = MANT_ONE;
      assign ip_in   = iip_r;
      assign f_in    = if_r;
      assign side_in = iside_r;
    end else begin : g_next
      assign v_in    = rv_r[k-2];
      assign m_in    = rm_r[k-2];
      assign ip_in   = rip_r[k-2];
      assign f_in    = rf_r[k-2];
      assign side_in = rside_r[k-2];
    end

    assign prod = (2*MW)'(m_in) * (2*MW)'(ROOT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k-1] <= 1'b0;
      end else begin
        rv_r[k-1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rm_r[k-1]    <= f_in[FW-k] ? prod[2*MW-2:MW-1] : m_in;
      rip_r[k-1]   <= ip_in;
      rf_r[k-1]    <= f_in;
      rside_r[k-1] <= side_in;
    end
  end

  // Scale by the integer part, saturating high and flushing to zero low.
  logic              ov_r;
  logic [PW-1:0]     opow_r;
  logic [SIDE_W-1:0] oside_r;
  logic [PW-1:0]     pow_nxt;
  logic [MW-1:0]     m_last;
  logic signed [IPW-1:0] ip_last;
  logic [1:0]        shl;
  logic [PW+1:0]     wide;
  logic [SW-1:0]     shr;

  always_comb begin
    m_last  = rm_r[FW-1];
    ip_last = rip_r[FW-1];
    shl     = '0;
    wide    = '0;
    shr     = '0;
    if (ip_last > signed'(IPW'(cdr_pkg::EXP_SAT_IP))) begin
      pow_nxt = '1;
    end else if (ip_last >= signed'(IPW'(cdr_pkg::EXP_BASE_IP))) begin
      shl  = 2'(ip_last - signed'(IPW'(cdr_pkg::EXP_BASE_IP)));
      wide = (PW + 2)'(m_last) << shl;
      pow_nxt = (wide[PW+1:PW] != 2'b00) ? '1 : wide[PW-1:0];
    end else begin
      shr = SW'(cdr_pkg::EXP_BASE_IP) - SW'(ip_last);
      if (shr > SW'(MW)) begin
        pow_nxt = '0;
      end else begin
        pow_nxt = PW'(m_last >> shr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= rv_r[FW-1];
    end
  end

  always_ff @(posedge clk) begin
    opow_r  <= pow_nxt;
    oside_r <= rside_r[FW-1];
  end

  assign out_valid = ov_r;
  assign pow       = opow_r;
  assign out_side  = oside_r;

endmodule

FILE: hw/rtl/cdr_cfg.sv
module cdr_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cdr_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cdr_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cdr_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output cdr_pkg::cfg_regs_t                   regs,
  output logic                                 busy,
  output logic                                 inj_req,
  input  logic                                 log_done,
  input  logic signed [cdr_pkg::LOG_W-1:0]     log_value
);

  localparam int TW  = cdr_pkg::TEMP_W;
  localparam int DW  = cdr_pkg::CFG_DATA_W;
  localparam int LW  = cdr_pkg::LOG_W;
  localparam int AW  = cdr_pkg::ALPHA_W;
  localparam int NW  = cdr_pkg::ALPHA_NUM_W;
  localparam int CW  = $clog2(NW);
  localparam logic [NW-1:0] ALPHA_ONE = NW'(1) << (NW - 1);

  cdr_pkg::cfg_state_t state_r, state_nxt;
  cdr_pkg::cfg_regs_t  regs_r, regs_nxt;
  logic [LW-1:0]       drem_r, drem_nxt;
  logic [LW-1:0]       ddiv_r, ddiv_nxt;
  logic [NW-1:0]       dnd_r, dnd_nxt;
  logic [NW-1:0]       dq_r, dq_nxt;
  logic [CW-1:0]       dcnt_r, dcnt_nxt;

  logic                  wr;
  cdr_pkg::cfg_reg_t     widx;
  logic [LW:0]           rem2;
  logic                  ge;

  assign wr   = psel & penable & pwrite;
  assign widx = cdr_pkg::cfg_reg_t'(paddr[cdr_pkg::REG_IDX_W+1:2]);
  assign rem2 = {drem_r, dnd_r[NW-1]};
  assign ge   = (rem2 >= {1'b0, ddiv_r});

  always_comb begin
    state_nxt = state_r;
    regs_nxt  = regs_r;
    drem_nxt  = drem_r;
    ddiv_nxt  = ddiv_r;
    dnd_nxt   = dnd_r;
    dq_nxt    = dq_r;
    dcnt_nxt  = dcnt_r;
    inj_req   = 1'b0;
    case (state_r)
      cdr_pkg::CFG_IDLE: begin
        if (wr) begin
          state_nxt = cdr_pkg::CFG_CHECK;
          case (widx)
            cdr_pkg::REG_TEMP_LOWER:      regs_nxt.temp_lower      = pwdata[TW-1:0];
            cdr_pkg::REG_TEMP_OPTIMUM:    regs_nxt.temp_optimum    = pwdata[TW-1:0];
            cdr_pkg::REG_TEMP_UPPER:      regs_nxt.temp_upper      = pwdata[TW-1:0];
            cdr_pkg::REG_DAYLEN_CRITICAL: regs_nxt.daylen_critical = pwdata[15:0];
            cdr_pkg::REG_DAYLEN_SLOPE:    regs_nxt.daylen_slope    = pwdata[15:0];
            cdr_pkg::REG_RATE_MAX_VEG:    regs_nxt.rate_max_veg    = pwdata[15:0];
            cdr_pkg::REG_RATE_MAX_TUBER:  regs_nxt.rate_max_tuber  = pwdata[15:0];
            cdr_pkg::REG_RATE_MAX_SEN:    regs_nxt.rate_max_sen    = pwdata[15:0];
            default: state_nxt = cdr_pkg::CFG_CHECK;
          endcase
        end
      end
      cdr_pkg::CFG_CHECK: begin
        if ((regs_r.temp_optimum <= regs_r.temp_lower) ||
            (regs_r.temp_upper <= regs_r.temp_optimum)) begin
          regs_nxt.alpha       = '0;
          regs_nxt.alpha_valid = 1'b0;
          state_nxt            = cdr_pkg::CFG_IDLE;
        end else begin
          state_nxt = cdr_pkg::CFG_INJECT;
        end
      end
      cdr_pkg::CFG_INJECT: begin
        inj_req   = 1'b1;
        state_nxt = cdr_pkg::CFG_WAIT;
      end
      cdr_pkg::CFG_WAIT: begin
        if (log_done) begin
          if (log_value[LW-1] || (log_value == '0)) begin
            regs_nxt.alpha       = '1;
            regs_nxt.alpha_valid = 1'b1;
            state_nxt            = cdr_pkg::CFG_IDLE;
          end else begin
            ddiv_nxt  = log_value;
            dnd_nxt   = ALPHA_ONE + NW'(log_value[LW-1:1]);
            drem_nxt  = '0;
            dq_nxt    = '0;
            dcnt_nxt  = '0;
            state_nxt = cdr_pkg::CFG_DIV;
          end
        end
      end
      cdr_pkg::CFG_DIV: begin
        drem_nxt = ge ? LW'(rem2 - {1'b0, ddiv_r}) : rem2[LW-1:0];
        dq_nxt   = {dq_r[NW-2:0], ge};
        dnd_nxt  = {dnd_r[NW-2:0], 1'b0};
        dcnt_nxt = dcnt_r + CW'(1);
        if (dcnt_r == CW'(NW - 1)) begin
          regs_nxt.alpha       = (dq_nxt[NW-1:AW] != '0) ? '1 : dq_nxt[AW-1:0];
          regs_nxt.alpha_valid = 1'b1;
          state_nxt            = cdr_pkg::CFG_IDLE;
        end
      end
      default: state_nxt = cdr_pkg::CFG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                <= cdr_pkg::CFG_IDLE;
      regs_r.temp_lower      <= cdr_pkg::RST_TEMP_LOWER;
      regs_r.temp_optimum    <= cdr_pkg::RST_TEMP_OPTIMUM;
      regs_r.temp_upper      <= cdr_pkg::RST_TEMP_UPPER;
      regs_r.daylen_critical <= cdr_pkg::RST_DAYLEN_CRIT;
      regs_r.daylen_slope    <= cdr_pkg::RST_DAYLEN_SLOPE;
      regs_r.rate_max_veg    <= cdr_pkg::RST_RMAX_VEG;
      regs_r.rate_max_tuber  <= cdr_pkg::RST_RMAX_TUBER;
      regs_r.rate_max_sen    <= cdr_pkg::RST_RMAX_SEN;
      regs_r.alpha           <= cdr_pkg::RST_ALPHA;
      regs_r.alpha_valid     <= 1'b1;
      dcnt_r                 <= '0;
    end else begin
      state_r <= state_nxt;
      regs_r  <= regs_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drem_r <= drem_nxt;
    ddiv_r <= ddiv_nxt;
    dnd_r  <= dnd_nxt;
    dq_r   <= dq_nxt;
  end

  always_comb begin
    case (widx)
      cdr_pkg::REG_TEMP_LOWER:      prdata = DW'(regs_r.temp_lower);
      cdr_pkg::REG_TEMP_OPTIMUM:    prdata = DW'(regs_r.temp_optimum);
      cdr_pkg::REG_TEMP_UPPER:      prdata = DW'(regs_r.temp_upper);
      cdr_pkg::REG_DAYLEN_CRITICAL: prdata = DW'(regs_r.daylen_critical);
      cdr_pkg::REG_DAYLEN_SLOPE:    prdata = DW'(regs_r.daylen_slope);
      cdr_pkg::REG_RATE_MAX_VEG:    prdata = DW'(regs_r.rate_max_veg);
      cdr_pkg::REG_RATE_MAX_TUBER:  prdata = DW'(regs_r.rate_max_tuber);
      cdr_pkg::REG_RATE_MAX_SEN:    prdata = DW'(regs_r.rate_max_sen);
      default:                      prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign regs   = regs_r;
  assign busy   = (state_r != cdr_pkg::CFG_IDLE);

endmodule

FILE: hw/rtl/crop_development_rate_unit.sv
// Crop development rate unit. Each daily transfer (start high while busy is low)
// carries a mean temperature (signed Q7.8 degrees) and a day length (Q5.11 hours);
// once it has passed the pipeline the unit raises out_strobe for exactly one cycle
// with the vegetative, tuberisation and senescence rates (Q0.16 per day). The
// receiver cannot stall the unit and must take each result in the cycle it
// appears. A new item may be started on every cycle while busy is low; results
// leave in the order the items came in, one per cycle at most. The pipeline is 86
// register stages deep: 63 in the logarithm unit (45 long-division stages, one
// leading-one stage, one normalizing stage and 16 squaring stages), two stages to
// form the power exponents, 18 in the power-of-two units and three stages of rate
// multiplication. Each register write taken while busy is low re-derives the
// shape exponent through one check, one injection, one pass through the logarithm
// unit and a bit-serial divider, and busy stays high meanwhile. The divider is
// skipped when the logarithm of the threshold ratio comes out as zero, and all
// after the check when the thresholds are out of order. Write registers only
// while no item is in flight. After reset the unit is ready at once.
module crop_development_rate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cdr_pkg::TEMP_W-1:0]   in_mean_temp,
  input  logic [cdr_pkg::DAYLEN_W-1:0]        in_day_length,
  output logic                                out_strobe,
  output logic [cdr_pkg::RATE_W-1:0]          out_rate_vegetative,
  output logic [cdr_pkg::RATE_W-1:0]          out_rate_tuber,
  output logic [cdr_pkg::RATE_W-1:0]          out_rate_senescence,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cdr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [cdr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [cdr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int TW   = cdr_pkg::TEMP_W;
  localparam int PLW  = cdr_pkg::DAYLEN_W;
  localparam int RW   = cdr_pkg::RATE_W;
  localparam int LW   = cdr_pkg::LOG_W;
  localparam int YW   = cdr_pkg::EXP_Y_W;
  localparam int PW   = cdr_pkg::POW_W;
  localparam int QW   = cdr_pkg::Q16_W;
  localparam int AW   = cdr_pkg::ALPHA_W;
  localparam int FW   = cdr_pkg::FRAC_W;
  // Side band through the logarithm unit: derivation tag, in-range flag, day length.
  localparam int LSW  = PLW + 2;
  localparam int PRW  = AW + 1 + LW;
  localparam int WW   = 2 * PLW;
  localparam int ZMW  = WW + QW;
  localparam int ZSH  = 27;
  localparam int ZW   = ZMW - ZSH;
  localparam int FTP  = RW + QW;
  localparam int VEGW = FTP + QW;

  cdr_pkg::cfg_regs_t regs;
  logic               inj_req;
  logic               accept;

  // Configuration registers and the exponent derivation.
  logic                 lg_valid;
  logic signed [LW-1:0] lg_value;
  logic [LSW-1:0]       lg_side;
  logic                 lg_tag;

  cdr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .regs      (regs),
    .busy      (busy),
    .inj_req   (inj_req),
    .log_done  (lg_valid & lg_tag),
    .log_value (lg_value)
  );

  assign accept = start & ~busy;

  // The temperature is in range only in the open interval between the thresholds
  // and only while the exponent is defined. Out-of-range items still flow through
  // the pipeline; their temperature response is forced to zero in stage C.
  logic signed [TW:0] t_diff;
  logic signed [TW:0] opt_diff;
  logic signed [TW:0] upper_diff;
  logic               in_range;
  logic [TW-1:0]      lg_num;

  assign t_diff     = (TW + 1)'(in_mean_temp) - (TW + 1)'(regs.temp_lower);
  assign opt_diff   = (TW + 1)'(regs.temp_optimum) - (TW + 1)'(regs.temp_lower);
  assign upper_diff = (TW + 1)'(regs.temp_upper) - (TW + 1)'(regs.temp_lower);
  assign in_range   = regs.alpha_valid && (in_mean_temp > regs.temp_lower) &&
                      (in_mean_temp < regs.temp_upper);
  // The derivation borrows the logarithm unit while busy, so it never meets an item.
  assign lg_num     = inj_req ? upper_diff[TW-1:0] : t_diff[TW-1:0];

  cdr_log2 #(
    .SIDE_W (LSW)
  ) u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept | inj_req),
    .num       (lg_num),
    .den       (opt_diff[TW-1:0]),
    .in_side   ({inj_req, in_range, in_day_length}),
    .out_valid (lg_valid),
    .log_value (lg_value),
    .out_side  (lg_side)
  );

  assign lg_tag = lg_side[LSW-1];

  // Stage A: alpha times the logarithm, and the photoperiod excess times the slope.
  logic                  a_v_r;
  logic signed [PRW-1:0] a_p_r;
  logic [WW-1:0]         a_w_r;
  logic                  a_inr_r;
  logic                  a_one_r;
  logic [PLW-1:0]        pl_item;

  assign pl_item = lg_side[PLW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= lg_valid & ~lg_tag;
    end
  end

  always_ff @(posedge clk) begin
    a_p_r   <= PRW'(signed'({1'b0, regs.alpha})) * PRW'(lg_value);
    a_w_r   <= WW'(regs.daylen_slope) * WW'(PLW'(pl_item - regs.daylen_critical));
    a_inr_r <= lg_side[PLW];
    a_one_r <= (pl_item < regs.daylen_critical);
  end

  // Stage B: exponents of both power-of-two evaluations. The arithmetic shift of
  // the product is the floor division by 2^12.
  logic                 b_v_r;
  logic signed [YW-1:0] b_y_r;
  logic [ZW-1:0]        b_z_r;
  logic                 b_inr_r;
  logic                 b_one_r;
  logic [ZMW-1:0]       zprod;

  assign zprod = ZMW'(a_w_r) * ZMW'(cdr_pkg::LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_y_r   <= a_p_r[12 +: YW];
    b_z_r   <= zprod[ZMW-1:ZSH];
    b_inr_r <= a_inr_r;
    b_one_r <= a_one_r;
  end

  // Power-of-two units, temperature and photoperiod side by side.
  logic          te_v;
  logic [PW-1:0] te_pow;
  logic          te_inr;
  logic          pe_v;
  logic [PW-1:0] pe_pow;
  logic          pe_one;

  cdr_exp2 #(
    .SIDE_W (1)
  ) u_exp2_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_v_r),
    .y         (b_y_r),
    .in_side   (b_inr_r),
    .out_valid (te_v),
    .pow       (te_pow),
    .out_side  (te_inr)
  );

  cdr_exp2 #(
    .SIDE_W (1)
  ) u_exp2_photo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_v_r),
    .y         (YW'(0) - YW'(b_z_r)),
    .in_side   (b_one_r),
    .out_valid (pe_v),
    .pow       (pe_pow),
    .out_side  (pe_one)
  );

  // Stage C: Wang-Engel shape 2v - v^2 and the photoperiod factor. A value v of
  // two or more means the temperature lies beyond the optimum curve and gives zero.
  logic            c_v_r;
  logic [QW-1:0]   c_ft_r;
  logic [QW-1:0]   c_fp_r;
  logic [QW-1:0]   v17;
  logic [2*QW-1:0] vv;
  logic [QW:0]     ft_full;

  assign v17     = te_pow[QW-1:0];
  assign vv      = (2 * QW)'(v17) * (2 * QW)'(v17);
  assign ft_full = {v17, 1'b0} - vv[2*QW-1:FW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= te_v & pe_v;
    end
  end

  always_ff @(posedge clk) begin
    c_ft_r <= (te_inr && (te_pow[PW-1:QW] == '0)) ? ft_full[QW-1:0] : '0;
    c_fp_r <= pe_one ? cdr_pkg::ONE_Q16 : pe_pow[QW-1:0];
  end

  // Stage D: each maximum rate times the temperature response.
  logic           d_v_r;
  logic [FTP-1:0] d_veg_r;
  logic [FTP-1:0] d_tub_r;
  logic [FTP-1:0] d_sen_r;
  logic [QW-1:0]  d_fp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d_veg_r <= FTP'(regs.rate_max_veg) * FTP'(c_ft_r);
    d_tub_r <= FTP'(regs.rate_max_tuber) * FTP'(c_ft_r);
    d_sen_r <= FTP'(regs.rate_max_sen) * FTP'(c_ft_r);
    d_fp_r  <= c_fp_r;
  end

  // Stage E: photoperiod factor on the vegetative rate, scaling and saturation,
  // straight into the output registers.
  logic            out_v_r;
  logic [RW-1:0]   out_veg_r;
  logic [RW-1:0]   out_tub_r;
  logic [RW-1:0]   out_sen_r;
  logic [VEGW-1:0] veg_full;
  logic [VEGW-1:0] veg_shift;
  logic [FTP-1:0]  tub_shift;
  logic [FTP-1:0]  sen_shift;

  assign veg_full  = VEGW'(d_veg_r) * VEGW'(d_fp_r);
  assign veg_shift = veg_full >> (2 * FW);
  assign tub_shift = d_tub_r >> FW;
  assign sen_shift = d_sen_r >> FW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_veg_r <= (veg_shift[VEGW-1:RW] != '0) ? '1 : veg_shift[RW-1:0];
    out_tub_r <= (tub_shift[FTP-1:RW] != '0) ? '1 : tub_shift[RW-1:0];
    out_sen_r <= (sen_shift[FTP-1:RW] != '0) ? '1 : sen_shift[RW-1:0];
  end

  assign out_strobe          = out_v_r;
  assign out_rate_vegetative = out_veg_r;
  assign out_rate_tuber      = out_tub_r;
  assign out_rate_senescence = out_sen_r;

endmodule

FILE: tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // An initial block fills a queue of pending daily items and reprograms the
  // configuration between phases, only when the unit is idle. A clocked driver
  // starts each item, and at the edge where a transfer is accepted it computes the
  // expected rates with a local copy of the temperature and day length response.
  // A clocked monitor compares every strobed result with the oldest expected one.

  localparam int RUN_LIMIT = 400000;

  typedef struct {
    logic signed [cdr_pkg::TEMP_W-1:0] temp;
    logic [cdr_pkg::DAYLEN_W-1:0]      daylen;
  } day_item_t;

  typedef struct {
    logic [cdr_pkg::RATE_W-1:0] veg;
    logic [cdr_pkg::RATE_W-1:0] tuber;
    logic [cdr_pkg::RATE_W-1:0] sen;
  } day_rates_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [cdr_pkg::TEMP_W-1:0] in_mean_temp = '0;
  logic [cdr_pkg::DAYLEN_W-1:0] in_day_length = '0;
  logic out_strobe;
  logic [cdr_pkg::RATE_W-1:0] out_rate_vegetative, out_rate_tuber, out_rate_senescence;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [cdr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [cdr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [cdr_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  crop_development_rate_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mean_temp(in_mean_temp), .in_day_length(in_day_length),
    .out_strobe(out_strobe), .out_rate_vegetative(out_rate_vegetative),
    .out_rate_tuber(out_rate_tuber), .out_rate_senescence(out_rate_senescence),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Local copy of the configuration and of the derived shape exponent.
  logic signed [cdr_pkg::TEMP_W-1:0] t_lower, t_opt, t_upper;
  logic [cdr_pkg::DAYLEN_W-1:0] p_crit, p_slope;
  logic [cdr_pkg::RATE_W-1:0] rmax_veg, rmax_tuber, rmax_sen;
  logic [cdr_pkg::ALPHA_W-1:0] alpha_m;
  logic alpha_ok;

  day_item_t  pending_days[$];
  day_rates_t expected_rates[$];
  int send_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(num/den) in Q16.16 by normalization and repeated squaring.
  function automatic int log2_q16(int num, int den);
    longint unsigned q;
    int e;
    int frac;
    q = (longint'(num) << 30) / longint'(den);
    e = 0;
    frac = 0;
    while (q >= (64'd1 << 31)) begin
      q = q >> 1;
      e++;
    end
    while (q < (64'd1 << 30)) begin
      q = q << 1;
      e--;
    end
    for (int i = 15; i >= 0; i--) begin
      q = (q * q) >> 30;
      if (q >= (64'd1 << 31)) begin
        q = q >> 1;
        frac = frac | (1 << i);
      end
    end
    return e * 65536 + frac;
  endfunction

  // 2^y with y in Q16, Q16 result saturated to 32 bits.
  function automatic longint pow2_q16(longint y);
    longint ip, s;
    longint unsigned f, m, c, r;
    ip = (y >= 0) ? (y >>> 16) : -((-y + 65535) >>> 16);
    f = y - ip * 65536;
    m = 64'd1 << 30;
    c = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      c = int_sqrt(c << 30);
      if (f[16-k]) m = (m * c) >> 30;
    end
    if (ip > 17) return 64'hFFFF_FFFF;
    if (ip >= 14) begin
      r = m << (ip - 14);
    end else begin
      s = 14 - ip;
      if (s >= 63) return 0;
      r = m >> s;
    end
    return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
  endfunction

  function automatic void derive_alpha();
    int lg;
    longint a;
    if (t_opt <= t_lower || t_upper <= t_opt) begin
      alpha_ok = 1'b0;
      alpha_m = '0;
      return;
    end
    lg = log2_q16(int'(t_upper) - int'(t_lower), int'(t_opt) - int'(t_lower));
    alpha_ok = 1'b1;
    if (lg <= 0) begin
      alpha_m = 16'hFFFF;
      return;
    end
    a = ((64'd1 << 28) + (lg >> 1)) / lg;
    alpha_m = (a > 65535) ? 16'hFFFF : a[15:0];
  endfunction

  // Wang-Engel response in Q16.
  function automatic longint wang_engel(int t);
    longint p, y, v;
    if (!alpha_ok || t <= t_lower || t >= t_upper || t_opt <= t_lower) return 0;
    p = longint'(alpha_m) * longint'(log2_q16(t - int'(t_lower), int'(t_opt) - int'(t_lower)));
    y = (p >= 0) ? (p >>> 12) : -((-p + 4095) >>> 12);
    v = pow2_q16(y);
    if (v >= 131072) return 0;
    return 2 * v - ((v * v) >>> 16);
  endfunction

  function automatic longint daylen_factor(int unsigned pl);
    longint w, z;
    if (pl < p_crit) return 65536;
    w = longint'(p_slope) * longint'(pl - p_crit);
    z = (w * 94548) >>> 27;
    return pow2_q16(-z);
  endfunction

  function automatic logic [cdr_pkg::RATE_W-1:0] clip16(longint x);
    return (x > 65535) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic day_rates_t predict_rates(day_item_t d);
    day_rates_t r;
    longint ft, fp;
    ft = wang_engel(int'(d.temp));
    fp = daylen_factor(d.daylen);
    r.veg   = clip16((longint'(rmax_veg) * ft * fp) >>> 32);
    r.tuber = clip16((longint'(rmax_tuber) * ft) >>> 16);
    r.sen   = clip16((longint'(rmax_sen) * ft) >>> 16);
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Driver: start stays high until the transfer is taken; a new item is offered
  // only once the previous transfer has completed.
  always @(posedge clk) begin
    day_item_t d;
    if (rst_n) begin
      if (start && !busy) begin
        d.temp = in_mean_temp;
        d.daylen = in_day_length;
        expected_rates.push_back(predict_rates(d));
      end
      if (!start || !busy) begin
        if (pending_days.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          d = pending_days.pop_front();
          start <= 1'b1;
          in_mean_temp <= d.temp;
          in_day_length <= d.daylen;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobe is one transfer that must match the oldest prediction.
  always @(posedge clk) begin
    day_rates_t e;
    if (rst_n && out_strobe) begin
      if (expected_rates.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        e = expected_rates.pop_front();
        if (out_rate_vegetative !== e.veg) report("rate_vegetative", out_rate_vegetative, e.veg);
        if (out_rate_tuber !== e.tuber) report("rate_tuber", out_rate_tuber, e.tuber);
        if (out_rate_senescence !== e.sen) report("rate_senescence", out_rate_senescence, e.sen);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Blocks until every queued item has been taken, every result has come
  // back, and the unit no longer reports busy.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_days.size() > 0 || start || expected_rates.size() > 0 || busy);
  endtask

  task automatic reg_write(cdr_pkg::cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= cdr_pkg::CFG_ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cdr_pkg::REG_TEMP_LOWER:      t_lower = value[14:0];
      cdr_pkg::REG_TEMP_OPTIMUM:    t_opt = value[14:0];
      cdr_pkg::REG_TEMP_UPPER:      t_upper = value[14:0];
      cdr_pkg::REG_DAYLEN_CRITICAL: p_crit = value[15:0];
      cdr_pkg::REG_DAYLEN_SLOPE:    p_slope = value[15:0];
      cdr_pkg::REG_RATE_MAX_VEG:    rmax_veg = value[15:0];
      cdr_pkg::REG_RATE_MAX_TUBER:  rmax_tuber = value[15:0];
      cdr_pkg::REG_RATE_MAX_SEN:    rmax_sen = value[15:0];
      default: ;
    endcase
    derive_alpha();
    // The unit re-derives the exponent after each write and holds busy meanwhile.
    repeat (2) @(posedge clk);
    drain();
  endtask

  task automatic set_thresholds(int lo, int opt, int hi);
    reg_write(cdr_pkg::REG_TEMP_LOWER, lo);
    reg_write(cdr_pkg::REG_TEMP_OPTIMUM, opt);
    reg_write(cdr_pkg::REG_TEMP_UPPER, hi);
  endtask

  task automatic set_daylen_and_rates(int crit, int slope, int rv, int rt, int rs);
    reg_write(cdr_pkg::REG_DAYLEN_CRITICAL, crit);
    reg_write(cdr_pkg::REG_DAYLEN_SLOPE, slope);
    reg_write(cdr_pkg::REG_RATE_MAX_VEG, rv);
    reg_write(cdr_pkg::REG_RATE_MAX_TUBER, rt);
    reg_write(cdr_pkg::REG_RATE_MAX_SEN, rs);
  endtask

  task automatic add_day(int t, int d);
    day_item_t x;
    x.temp = cdr_pkg::TEMP_W'(t);
    x.daylen = cdr_pkg::DAYLEN_W'(d);
    pending_days.push_back(x);
  endtask

  function automatic int pick(int lo, int hi);
    if (lo < -16384) lo = -16384;
    if (hi > 16383) hi = 16383;
    if (hi < lo) hi = lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Most temperatures fall around the temperature window and half of the day lengths
  // around the critical one, so the response curve is exercised; the rest use any field value.
  task automatic add_random_days(int n);
    int t, d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) t = pick(int'(t_lower) - 64, int'(t_upper) + 64);
      else t = pick(-16384, 16383);
      if ($urandom_range(1)) d = int'(p_crit) - 4096 + int'($urandom_range(8192));
      else d = $urandom_range(65535);
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      add_day(t, d);
    end
  endtask

  initial begin
    t_lower = cdr_pkg::RST_TEMP_LOWER;
    t_opt = cdr_pkg::RST_TEMP_OPTIMUM;
    t_upper = cdr_pkg::RST_TEMP_UPPER;
    p_crit = cdr_pkg::RST_DAYLEN_CRIT;
    p_slope = cdr_pkg::RST_DAYLEN_SLOPE;
    rmax_veg = cdr_pkg::RST_RMAX_VEG;
    rmax_tuber = cdr_pkg::RST_RMAX_TUBER;
    rmax_sen = cdr_pkg::RST_RMAX_SEN;
    derive_alpha();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed days on the reset configuration: field extremes, both edges of
    // the open temperature window, the optimum, and the critical day length.
    add_day(-16384, 0);
    add_day(16383, 65535);
    add_day(t_lower, p_crit);
    add_day(t_lower + 1, p_crit - 1);
    add_day(t_opt, p_crit);
    add_day(t_opt, 0);
    add_day(t_opt, 65535);
    add_day(t_upper - 1, p_crit + 1);
    add_day(t_upper, 1000);
    add_day(2000, 30000);
    add_day(5000, 21000);
    add_day(-1, 49152);
    add_day(15360, 22000);
    add_day(-10240, 22000);
    drain();

    // Back-to-back transfers on the reset configuration.
    send_idle_pct = 0;
    add_random_days(90);
    drain();

    // A sparse sender, with a full pause in the middle.
    send_idle_pct = 82;
    set_thresholds(-16384, 0, 16383);
    set_daylen_and_rates(0, 65535, 65535, 65535, 65535);
    add_random_days(50);
    drain();
    add_random_days(50);
    drain();

    // Thresholds out of order leave every rate at zero.
    send_idle_pct = 37;
    set_thresholds(3000, 2000, 5000);
    add_random_days(15);
    drain();
    set_thresholds(1000, 1000, 5000);
    add_random_days(10);
    drain();
    set_thresholds(0, 3000, 3000);
    add_random_days(10);
    drain();

    // A narrow upper slope that saturates the exponent.
    set_thresholds(0, 1000, 1040);
    set_daylen_and_rates(65535, 0, 40000, 30000, 20000);
    add_random_days(60);
    drain();

    // A broad window with a very short optimum offset.
    send_idle_pct = 0;
    set_thresholds(-10240, -10239, 15360);
    set_daylen_and_rates(49152, 30000, 1000, 65535, 12);
    add_random_days(60);
    drain();

    // Random configurations within the stated ranges.
    for (int ph = 0; ph < 4; ph++) begin
      int a, b, c;
      send_idle_pct = (ph % 2) ? 82 : 37;
      a = pick(-10240, 12000);
      b = pick(a + 1, a + 3000);
      c = pick(b + 1, b + 8000);
      set_thresholds(a, b, c);
      set_daylen_and_rates($urandom_range(49152), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535));
      add_random_days(50);
      drain();
    end

    // Back to the reset values for a final streaming pass.
    send_idle_pct = 0;
    set_thresholds(cdr_pkg::RST_TEMP_LOWER, cdr_pkg::RST_TEMP_OPTIMUM,
                   cdr_pkg::RST_TEMP_UPPER);
    set_daylen_and_rates(cdr_pkg::RST_DAYLEN_CRIT, cdr_pkg::RST_DAYLEN_SLOPE,
                         cdr_pkg::RST_RMAX_VEG, cdr_pkg::RST_RMAX_TUBER,
                         cdr_pkg::RST_RMAX_SEN);
    add_random_days(50);
    drain();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_rates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
